// ----- hdl/gtpe_pkg.sv -----
`default_nettype none

package gtpe_pkg;

  localparam int PEAK_W = 24;

  localparam logic signed [PEAK_W-1:0] PEAK_MAX = 24'sh7FFFFF;
  localparam logic signed [PEAK_W-1:0] PEAK_MIN = 24'sh800000;

endpackage

`default_nettype wire

// ----- hdl/grid_tangent_peak_estimator.sv -----
// Grid tangent peak estimator.
// Input channel (sample_i, last_sample_i) and output channel (peak_o,
// short_run_o) each use a valid/stall pair; a transfer happens on a rising
// edge with valid high and stall low. last_sample_i closes a run; exactly
// one result follows each closing sample, none otherwise.
// From the third sample on, every sample starts one tangent-intersection
// estimate (the closing sample of a long run starts two). An estimate runs
// on one shift-and-add multiplier over the two products and one restoring
// divider that takes one numerator bit per cycle; equal slopes skip both.
// in_stall_o stays high while an estimate or the result load is pending.
// The result is loaded into an output register from S_IDLE once the run is
// closed; while out_stall_i holds it, the next run may already start,
// but a further result waits until the register is free.
// Reset clears the sample history, the held slope, the sample count, the
// running peak and the output valid; after each run the history, slope,
// count and peak are cleared again, so runs are independent.
`default_nettype none

module grid_tangent_peak_estimator
  import gtpe_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0]     sample_i,
  input  wire                               last_sample_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [PEAK_W-1:0]          peak_o,
  output logic                              short_run_o
);

  localparam int N  = SAMPLE_BITS;
  localparam int SL = N + 3;          // scaled slope
  localparam int AW = N + 4;          // 2*y0 + d0
  localparam int BW = N + 2;          // -2*y1
  localparam int W  = 2 * N + 6;      // numerator
  localparam int DW = N + 5;          // divisor magnitude and remainder
  localparam int CW = $clog2(W);
  localparam int SW = (N > PEAK_W) ? N : PEAK_W + 1;

  localparam logic signed [SW-1:0] SAT_HI = SW'(PEAK_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(PEAK_MIN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_A,
    S_MUL_B,
    S_DSET,
    S_DIV,
    S_DONE,
    S_NEXT
  } state_e;

  localparam state_e S_OUT_UNUSED = S_IDLE;

  function automatic logic signed [PEAK_W-1:0] sat24(input logic signed [SW-1:0] v);
    logic signed [PEAK_W-1:0] r;
    priority if (v > SAT_HI) r = PEAK_MAX;
    else if (v < SAT_LO)     r = PEAK_MIN;
    else                     r = PEAK_W'(v);
    return r;
  endfunction

  state_e                   state_q;
  logic                     out_pend_q;
  logic signed [N-1:0]      hist_q [3];
  logic signed [SL-1:0]     slope_q;
  logic [1:0]               seen_q;
  logic signed [PEAK_W-1:0] run_peak_q;
  logic                     last_q;
  logic                     second_q;
  logic signed [N-1:0]      ey0_q, ey1_q;
  logic signed [SL-1:0]     ed0_q, ed1_q;
  logic signed [W-1:0]      acc_q, mc_q;
  logic [SL-1:0]            mr_q;
  logic [CW-1:0]            cnt_q;
  logic [DW-1:0]            uden_q, rem_q;
  logic                     dneg_q, qneg_q;
  logic [PEAK_W-1:0]        q_q;
  logic                     big_q;
  logic                     out_valid_q;
  logic signed [PEAK_W-1:0] peak_q;
  logic                     short_q;

  // combinational helpers
  logic                     in_xfer, out_free;
  logic signed [PEAK_W-1:0] x_sat;
  logic [1:0]               seen_inc;
  logic signed [SL-1:0]     slope_first, slope_mid, slope_last;
  logic signed [AW-1:0]     opnd_a;
  logic signed [BW-1:0]     opnd_b;
  logic signed [N+3:0]      dslope;
  logic [N+3:0]             dslope_mag;
  logic signed [N:0]        ysum;
  logic signed [PEAK_W-1:0] mid_sat;
  logic signed [W-1:0]      pp, acc_step, acc_mag;
  logic [DW-1:0]            dt, rem_step;
  logic                     dge;
  logic                     qbig;
  logic signed [PEAK_W-1:0] q_cand;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_stall_o = (state_q != S_IDLE) || out_pend_q;
    x_sat      = sat24(SW'(sample_i));
    seen_inc   = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;

    // slopes scaled by 2x spacing; window hist[1..2], sample; last: hist[0..2]
    slope_first = (SL'(hist_q[2]) <<< 2) - (SL'(hist_q[1]) <<< 1) - SL'(hist_q[1])
                  - SL'(sample_i);
    slope_mid   = SL'(sample_i) - SL'(hist_q[1]);
    slope_last  = SL'(hist_q[0]) - (SL'(hist_q[1]) <<< 2) + (SL'(hist_q[2]) <<< 1)
                  + SL'(hist_q[2]);

    opnd_a     = (AW'(ey0_q) <<< 1) + AW'(ed0_q);
    opnd_b     = -(BW'(ey1_q) <<< 1);
    dslope     = (N+4)'(ed1_q) - (N+4)'(ed0_q);
    dslope_mag = dslope[N+3] ? (N+4)'(-dslope) : (N+4)'(dslope);
    ysum       = (N+1)'(ey0_q) + (N+1)'(ey1_q);
    mid_sat    = sat24(SW'($signed(ysum[N:1])));

    // signed multiplier: the top bit of the multiplier weighs negative
    pp       = mr_q[0] ? mc_q : '0;
    acc_step = (cnt_q == CW'(SL - 1)) ? acc_q - pp : acc_q + pp;
    acc_mag  = acc_q[W-1] ? -acc_q : acc_q;

    dt       = {rem_q[DW-2:0], acc_q[W-1]};
    dge      = dt >= uden_q;
    rem_step = dge ? dt - uden_q : dt;

    qbig   = big_q || q_q[PEAK_W-1];
    q_cand = qneg_q ? (qbig ? PEAK_MIN : -$signed(q_q))
                    : (qbig ? PEAK_MAX : $signed(q_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_pend_q  <= 1'b0;
      hist_q[0]   <= '0;
      hist_q[1]   <= '0;
      hist_q[2]   <= '0;
      slope_q     <= '0;
      seen_q      <= '0;
      run_peak_q  <= '0;
      last_q      <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !(state_q == S_IDLE && out_pend_q)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (out_pend_q && out_free) begin
            // hand over the finished run and clear for the next one
            out_valid_q <= 1'b1;
            peak_q      <= run_peak_q;
            short_q     <= (seen_q != 2'd3);
            out_pend_q  <= 1'b0;
            hist_q[0]   <= '0;
            hist_q[1]   <= '0;
            hist_q[2]   <= '0;
            slope_q     <= '0;
            seen_q      <= '0;
            run_peak_q  <= '0;
          end else if (in_xfer) begin
            if (x_sat > run_peak_q) begin
              run_peak_q <= x_sat;
            end
            hist_q[0] <= hist_q[1];
            hist_q[1] <= hist_q[2];
            hist_q[2] <= sample_i;
            seen_q    <= seen_inc;
            last_q    <= last_sample_i;
            second_q  <= 1'b0;
            if (seen_inc == 2'd3) begin
              ey0_q   <= hist_q[1];
              ey1_q   <= hist_q[2];
              ed0_q   <= (seen_q == 2'd2) ? slope_first : slope_q;
              ed1_q   <= slope_mid;
              slope_q <= slope_mid;
              state_q <= S_LOAD;
            end else if (last_sample_i) begin
              out_pend_q <= 1'b1;
            end
          end
        end

        S_LOAD: begin
          if (ed0_q == ed1_q) begin
            if (mid_sat > run_peak_q) begin
              run_peak_q <= mid_sat;
            end
            state_q <= S_NEXT;
          end else begin
            acc_q   <= '0;
            mc_q    <= W'(opnd_a);
            mr_q    <= ed1_q;
            cnt_q   <= '0;
            uden_q  <= {dslope_mag, 1'b0};
            dneg_q  <= dslope[N+3];
            state_q <= S_MUL_A;
          end
        end

        S_MUL_A: begin
          acc_q <= acc_step;
          if (cnt_q == CW'(SL - 1)) begin
            mc_q    <= W'(opnd_b);
            mr_q    <= ed0_q;
            cnt_q   <= '0;
            state_q <= S_MUL_B;
          end else begin
            mc_q  <= mc_q <<< 1;
            mr_q  <= mr_q >> 1;
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_MUL_B: begin
          acc_q <= acc_step;
          mc_q  <= mc_q <<< 1;
          mr_q  <= mr_q >> 1;
          if (cnt_q == CW'(SL - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DSET;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_DSET: begin
          acc_q   <= acc_mag;
          qneg_q  <= acc_q[W-1] ^ dneg_q;
          rem_q   <= '0;
          q_q     <= '0;
          big_q   <= 1'b0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          // one quotient bit per cycle; remember any bit pushed off the top
          acc_q <= acc_q <<< 1;
          rem_q <= rem_step;
          q_q   <= {q_q[PEAK_W-2:0], dge};
          big_q <= big_q || q_q[PEAK_W-1];
          if (cnt_q == CW'(W - 1)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_DONE: begin
          if (q_cand > run_peak_q) begin
            run_peak_q <= q_cand;
          end
          state_q <= S_NEXT;
        end

        S_NEXT: begin
          if (last_q && !second_q) begin
            // closing sample: estimate between the last two points as well
            second_q <= 1'b1;
            ey0_q    <= hist_q[1];
            ey1_q    <= hist_q[2];
            ed0_q    <= slope_q;
            ed1_q    <= slope_last;
            state_q  <= S_LOAD;
          end else begin
            out_pend_q <= last_q;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_OUT_UNUSED;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign peak_o      = peak_q;
  assign short_run_o = short_q;

`ifndef SYNTHESIS
  a_short_run_skips_estimate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_sample_i && (seen_q == 2'd0 || seen_q == 2'd1)
    |=> state_q == S_IDLE && out_pend_q)
    else $error("short run did not go straight to the result");

  a_peak_never_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_peak_q[PEAK_W-1])
    else $error("running peak fell below zero");

  a_estimate_needs_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> seen_q == 2'd3)
    else $error("estimate running with fewer than three samples");

  a_result_dropped_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(state_q == S_IDLE && out_pend_q) |=> !out_valid_o)
    else $error("result shown again after its transfer");

  a_divider_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == CW'(W - 1) |=> state_q == S_DONE)
    else $error("divider did not finish after the last numerator bit");
`endif

endmodule

`default_nettype wire
